// ===== design/fbs_pkg.sv =====
package fbs_pkg;

    localparam int RF_DEPTH = 16;
    localparam int RF_AW    = 4;
    localparam int NIB_W    = 4;

    localparam logic [2:0] SRC_AQ = 3'd0;
    localparam logic [2:0] SRC_AB = 3'd1;
    localparam logic [2:0] SRC_ZQ = 3'd2;
    localparam logic [2:0] SRC_ZB = 3'd3;
    localparam logic [2:0] SRC_ZA = 3'd4;
    localparam logic [2:0] SRC_DA = 3'd5;
    localparam logic [2:0] SRC_DQ = 3'd6;
    localparam logic [2:0] SRC_DZ = 3'd7;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUBR  = 3'd1;
    localparam logic [2:0] OP_SUBS  = 3'd2;
    localparam logic [2:0] OP_OR    = 3'd3;
    localparam logic [2:0] OP_AND   = 3'd4;
    localparam logic [2:0] OP_NOTRS = 3'd5;
    localparam logic [2:0] OP_EXOR  = 3'd6;
    localparam logic [2:0] OP_EXNOR = 3'd7;

    localparam logic [2:0] DST_QREG  = 3'd0;
    localparam logic [2:0] DST_NOP   = 3'd1;
    localparam logic [2:0] DST_RAMA  = 3'd2;
    localparam logic [2:0] DST_RAMF  = 3'd3;
    localparam logic [2:0] DST_RAMQD = 3'd4;
    localparam logic [2:0] DST_RAMD  = 3'd5;
    localparam logic [2:0] DST_RAMQU = 3'd6;
    localparam logic [2:0] DST_RAMU  = 3'd7;

    typedef struct packed {
        logic [2:0]       source_sel;
        logic [2:0]       operation;
        logic [2:0]       dest_sel;
        logic [RF_AW-1:0] addr_a;
        logic [RF_AW-1:0] addr_b;
        logic [NIB_W-1:0] d_in;
        logic             carry_in;
        logic             ram0_in;
        logic             ram3_in;
        logic             q0_in;
        logic             q3_in;
        logic             out_enable_n;
    } t_in_req;

    typedef struct packed {
        logic [NIB_W-1:0] y_out;
        logic             y_driven;
        logic             carry_out;
        logic             propagate_n;
        logic             generate_n;
        logic             overflow;
        logic             f_zero;
        logic             f_sign;
        logic             ram0_out;
        logic             ram3_out;
        logic             q0_out;
        logic             q3_out;
    } t_out_req;

endpackage

// ===== design/fbs_if.sv =====
interface fbs_in_if;
    logic              valid;
    logic              ready;
    fbs_pkg::t_in_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fbs_out_if;
    logic              valid;
    logic              ready;
    fbs_pkg::t_out_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/four_bit_slice_alu.sv =====
// channel  | dir | port   | payload
// ---------+-----+--------+----------------------------------------------
// instr    | in  | i_req  | fbs_pkg::t_in_req  (one microinstruction)
// result   | out | o_rsp  | fbs_pkg::t_out_req (Y, flags, shift-out pins)
//
// One microinstruction per clock while results are taken; the result is registered through
// register file read (registered RAM port), then ALU, write-back and output reg.
// A write to the entry the following instruction reads is forwarded.
// Reset clears Q and the per-entry valid bits of the register file (reads as 0).
// Input stalls only when stage 1 and the output register are full and the result is not taken.
module four_bit_slice_alu (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fbs_in_if.sink    i_req,
    fbs_out_if.source o_rsp
);

    localparam int AW = fbs_pkg::RF_AW;
    localparam int NW = fbs_pkg::NIB_W;

    fbs_pkg::t_in_req  r_s1;
    logic              r_s1_valid;
    fbs_pkg::t_out_req r_out;
    logic              r_out_valid;
    logic [NW-1:0]     r_q;
    logic [fbs_pkg::RF_DEPTH-1:0] r_vld;
    logic              r_a_vld;
    logic              r_b_vld;
    logic              r_fw_we;
    logic [AW-1:0]     r_fw_addr;
    logic [NW-1:0]     r_fw_data;

    logic              s1_adv;
    logic              in_acc;
    logic [NW-1:0]     ram_a;
    logic [NW-1:0]     ram_b;
    logic [NW-1:0]     a_val;
    logic [NW-1:0]     b_val;
    logic [NW-1:0]     r_opnd;
    logic [NW-1:0]     s_opnd;
    logic [NW-1:0]     p;
    logic [NW-1:0]     g;
    logic              pall;
    logic              gany;
    logic              gfull;
    logic              c3;
    logic              c4;
    logic              cn;
    logic              xo;
    logic              zo;
    logic [NW-1:0]     sum;
    logic [NW-1:0]     f;
    logic [NW-1:0]     y;
    logic              wr_en;
    logic [NW-1:0]     n_wdata;
    logic [NW-1:0]     n_q;
    fbs_pkg::t_out_req n_out;

    assign s1_adv = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign in_acc = i_req.valid && i_req.ready;

    fbs_ram #(
        .WIDTH (NW),
        .DEPTH (fbs_pkg::RF_DEPTH)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (r_s1.addr_b),
        .i_wdata   (n_wdata),
        .i_re      (in_acc),
        .i_raddr_a (i_req.payload.addr_a),
        .i_raddr_b (i_req.payload.addr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    always_comb begin
        if (r_fw_we && r_fw_addr == r_s1.addr_a) begin
            a_val = r_fw_data;
        end else begin
            a_val = r_a_vld ? ram_a : '0;
        end
        if (r_fw_we && r_fw_addr == r_s1.addr_b) begin
            b_val = r_fw_data;
        end else begin
            b_val = r_b_vld ? ram_b : '0;
        end
    end

    always_comb begin
        cn = r_s1.carry_in;
        case (r_s1.source_sel)
            fbs_pkg::SRC_AQ: begin r_opnd = a_val;      s_opnd = r_q;   end
            fbs_pkg::SRC_AB: begin r_opnd = a_val;      s_opnd = b_val; end
            fbs_pkg::SRC_ZQ: begin r_opnd = '0;         s_opnd = r_q;   end
            fbs_pkg::SRC_ZB: begin r_opnd = '0;         s_opnd = b_val; end
            fbs_pkg::SRC_ZA: begin r_opnd = '0;         s_opnd = a_val; end
            fbs_pkg::SRC_DA: begin r_opnd = r_s1.d_in;  s_opnd = a_val; end
            fbs_pkg::SRC_DQ: begin r_opnd = r_s1.d_in;  s_opnd = r_q;   end
            default:         begin r_opnd = r_s1.d_in;  s_opnd = '0;    end
        endcase
        if (r_s1.operation == fbs_pkg::OP_SUBR || r_s1.operation == fbs_pkg::OP_NOTRS
            || r_s1.operation == fbs_pkg::OP_EXOR) begin
            r_opnd = ~r_opnd;
        end
        if (r_s1.operation == fbs_pkg::OP_SUBS) begin
            s_opnd = ~s_opnd;
        end

        p     = r_opnd | s_opnd;
        g     = r_opnd & s_opnd;
        pall  = &p;
        gany  = |g;
        gfull = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | (p[3] & p[2] & p[1] & g[0]);
        c4    = gfull | (pall & cn);
        c3    = g[2] | (p[2] & g[1]) | (p[2] & p[1] & g[0]) | (p[2] & p[1] & p[0] & cn);
        sum   = r_opnd + s_opnd + {{(NW-1){1'b0}}, cn};
        xo    = !p[2] | (!g[2] & !p[1]) | (!g[2] & !g[1] & !p[0])
                | (!g[2] & !g[1] & !g[0] & cn);
        zo    = !p[3] | (!g[3] & !p[2]) | (!g[3] & !g[2] & !p[1])
                | (!g[3] & !g[2] & !g[1] & !p[0]) | (!g[3] & !g[2] & !g[1] & !g[0] & cn);

        n_out = '0;
        case (r_s1.operation)
            fbs_pkg::OP_ADD, fbs_pkg::OP_SUBR, fbs_pkg::OP_SUBS: begin
                f                 = sum;
                n_out.propagate_n = !pall;
                n_out.generate_n  = !gfull;
                n_out.carry_out   = c4;
                n_out.overflow    = c3 ^ c4;
            end
            fbs_pkg::OP_OR: begin
                f                 = r_opnd | s_opnd;
                n_out.propagate_n = 1'b0;
                n_out.generate_n  = pall;
                n_out.carry_out   = !pall | cn;
                n_out.overflow    = !pall | cn;
            end
            fbs_pkg::OP_AND, fbs_pkg::OP_NOTRS: begin
                f                 = r_opnd & s_opnd;
                n_out.propagate_n = 1'b0;
                n_out.generate_n  = !gany;
                n_out.carry_out   = gany | cn;
                n_out.overflow    = gany | cn;
            end
            default: begin
                f                 = ~(r_opnd ^ s_opnd);
                n_out.propagate_n = gany;
                n_out.generate_n  = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | pall;
                n_out.carry_out   = !(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1])
                                      | (pall & (g[0] | !cn)));
                n_out.overflow    = xo ^ zo;
            end
        endcase

        y       = (r_s1.dest_sel == fbs_pkg::DST_RAMA) ? a_val : f;
        wr_en   = 1'b0;
        n_wdata = f;
        n_q     = r_q;
        case (r_s1.dest_sel)
            fbs_pkg::DST_QREG: begin
                n_q = f;
            end
            fbs_pkg::DST_RAMA, fbs_pkg::DST_RAMF: begin
                wr_en = s1_adv;
            end
            fbs_pkg::DST_RAMQD, fbs_pkg::DST_RAMD: begin
                wr_en   = s1_adv;
                n_wdata = {r_s1.ram3_in, f[NW-1:1]};
                if (r_s1.dest_sel == fbs_pkg::DST_RAMQD) begin
                    n_q = {r_s1.q3_in, r_q[NW-1:1]};
                end
                n_out.ram0_out = f[0];
                n_out.q0_out   = r_q[0];
            end
            fbs_pkg::DST_RAMQU, fbs_pkg::DST_RAMU: begin
                wr_en   = s1_adv;
                n_wdata = {f[NW-2:0], r_s1.ram0_in};
                if (r_s1.dest_sel == fbs_pkg::DST_RAMQU) begin
                    n_q = {r_q[NW-2:0], r_s1.q0_in};
                end
                n_out.ram3_out = f[NW-1];
                n_out.q3_out   = r_q[NW-1];
            end
            default: begin
            end
        endcase

        n_out.y_out    = r_s1.out_enable_n ? '0 : y;
        n_out.y_driven = !r_s1.out_enable_n;
        n_out.f_zero   = (f == '0);
        n_out.f_sign   = f[NW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_q         <= '0;
            r_vld       <= '0;
            r_fw_we     <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_q         <= n_q;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_vld[r_s1.addr_b] <= 1'b1;
            end
            if (in_acc) begin
                r_fw_we <= wr_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1      <= i_req.payload;
            r_a_vld   <= r_vld[i_req.payload.addr_a];
            r_b_vld   <= r_vld[i_req.payload.addr_b];
            r_fw_addr <= r_s1.addr_b;
            r_fw_data <= n_wdata;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid)
        else $error("stage 1 item dropped while stalled");

    a_wr_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_vld[$past(r_s1.addr_b)])
        else $error("register file write did not set entry valid");

    a_y_undriven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.payload.y_driven |-> o_rsp.payload.y_out == '0)
        else $error("Y nonzero while not driven");

    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |-> i_req.ready)
        else $error("input stalled with free output register");
`endif

endmodule

// ===== design/fbs_ram.sv =====
module fbs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== sim/tb_four_bit_slice_alu.sv =====
`timescale 1ns / 100ps

module tb_four_bit_slice_alu;

    localparam int RUN_LIMIT_NS = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    fbs_in_if  req_if ();
    fbs_out_if rsp_if ();

    four_bit_slice_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [fbs_pkg::NIB_W-1:0] regfile_mirror [fbs_pkg::RF_DEPTH];
    logic [fbs_pkg::NIB_W-1:0] q_mirror;
    fbs_pkg::t_out_req         predicted_rsp [$];

    int                        n_sent;
    int                        n_checked;
    int                        n_errors;
    int                        src_idle_pct;
    bit                        quiet;
    logic [fbs_pkg::RF_AW-1:0] last_addr_b;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d results still pending", $time, predicted_rsp.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Behavior of one microinstruction; updates the mirrored register file and Q.
    function automatic fbs_pkg::t_out_req predict_slice(input fbs_pkg::t_in_req ins);
        logic [fbs_pkg::NIB_W-1:0] a, b, q, r, s, p, g, f, y;
        logic                      cin, pall, gany, c3, c4, co, pn, gn, ovr, x, z;
        fbs_pkg::t_out_req         res;
        a   = regfile_mirror[ins.addr_a];
        b   = regfile_mirror[ins.addr_b];
        q   = q_mirror;
        cin = ins.carry_in;
        case (ins.source_sel)
            fbs_pkg::SRC_AQ: begin r = a;        s = q;  end
            fbs_pkg::SRC_AB: begin r = a;        s = b;  end
            fbs_pkg::SRC_ZQ: begin r = '0;       s = q;  end
            fbs_pkg::SRC_ZB: begin r = '0;       s = b;  end
            fbs_pkg::SRC_ZA: begin r = '0;       s = a;  end
            fbs_pkg::SRC_DA: begin r = ins.d_in; s = a;  end
            fbs_pkg::SRC_DQ: begin r = ins.d_in; s = q;  end
            default: begin r = ins.d_in; s = '0; end
        endcase
        if (ins.operation == fbs_pkg::OP_SUBR || ins.operation == fbs_pkg::OP_NOTRS ||
            ins.operation == fbs_pkg::OP_EXOR)
            r = ~r;
        if (ins.operation == fbs_pkg::OP_SUBS)
            s = ~s;

        p    = r | s;
        g    = r & s;
        pall = &p;
        gany = |g;
        c4   = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | (p[3] & p[2] & p[1] & g[0])
               | (pall & cin);
        c3   = g[2] | (p[2] & g[1]) | (p[2] & p[1] & g[0]) | (p[2] & p[1] & p[0] & cin);

        case (ins.operation)
            fbs_pkg::OP_ADD, fbs_pkg::OP_SUBR, fbs_pkg::OP_SUBS: begin
                f   = r + s + cin;
                pn  = ~pall;
                gn  = ~(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1])
                        | (p[3] & p[2] & p[1] & g[0]));
                co  = c4;
                ovr = c3 ^ c4;
            end
            fbs_pkg::OP_OR: begin
                f   = r | s;
                pn  = 1'b0;
                gn  = pall;
                co  = ~pall | cin;
                ovr = co;
            end
            fbs_pkg::OP_AND, fbs_pkg::OP_NOTRS: begin
                f   = r & s;
                pn  = 1'b0;
                gn  = ~gany;
                co  = gany | cin;
                ovr = co;
            end
            default: begin
                f   = ~(r ^ s);
                pn  = gany;
                gn  = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | pall;
                co  = ~(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | (pall & (g[0] | ~cin)));
                x   = ~p[2] | (~g[2] & ~p[1]) | (~g[2] & ~g[1] & ~p[0])
                      | (~g[2] & ~g[1] & ~g[0] & cin);
                z   = ~p[3] | (~g[3] & ~p[2]) | (~g[3] & ~g[2] & ~p[1])
                      | (~g[3] & ~g[2] & ~g[1] & ~p[0])
                      | (~g[3] & ~g[2] & ~g[1] & ~g[0] & cin);
                ovr = x ^ z;
            end
        endcase

        res = '0;
        y   = (ins.dest_sel == fbs_pkg::DST_RAMA) ? a : f;
        case (ins.dest_sel)
            fbs_pkg::DST_QREG: q_mirror = f;
            fbs_pkg::DST_RAMA, fbs_pkg::DST_RAMF: regfile_mirror[ins.addr_b] = f;
            fbs_pkg::DST_RAMQD, fbs_pkg::DST_RAMD: begin
                regfile_mirror[ins.addr_b] = {ins.ram3_in, f[3:1]};
                if (ins.dest_sel == fbs_pkg::DST_RAMQD)
                    q_mirror = {ins.q3_in, q[3:1]};
                res.ram0_out = f[0];
                res.q0_out   = q[0];
            end
            fbs_pkg::DST_RAMQU, fbs_pkg::DST_RAMU: begin
                regfile_mirror[ins.addr_b] = {f[2:0], ins.ram0_in};
                if (ins.dest_sel == fbs_pkg::DST_RAMQU)
                    q_mirror = {q[2:0], ins.q0_in};
                res.ram3_out = f[3];
                res.q3_out   = q[3];
            end
            default: ;
        endcase

        res.y_out       = ins.out_enable_n ? '0 : y;
        res.y_driven    = ~ins.out_enable_n;
        res.carry_out   = co;
        res.propagate_n = pn;
        res.generate_n  = gn;
        res.overflow    = ovr;
        res.f_zero      = (f == '0);
        res.f_sign      = f[3];
        return res;
    endfunction

    function automatic fbs_pkg::t_in_req build_instr(input logic [2:0] src,
                                                     input logic [2:0] op,
                                                     input logic [2:0] dst,
                                                     input logic [3:0] aa,
                                                     input logic [3:0] ab,
                                                     input logic [3:0] d,
                                                     input logic cin);
        fbs_pkg::t_in_req ins;
        ins            = '0;
        ins.source_sel = src;
        ins.operation  = op;
        ins.dest_sel   = dst;
        ins.addr_a     = aa;
        ins.addr_b     = ab;
        ins.d_in       = d;
        ins.carry_in   = cin;
        return ins;
    endfunction

    function automatic fbs_pkg::t_in_req random_instr();
        fbs_pkg::t_in_req ins;
        logic [31:0]      rnd;
        rnd = $urandom;
        ins = rnd[$bits(fbs_pkg::t_in_req)-1:0];
        // read back the entry just written, to hit the forwarding path
        if ($urandom_range(0, 2) == 0)
            ins.addr_a = last_addr_b;
        if ($urandom_range(0, 3) == 0)
            ins.addr_b = last_addr_b;
        ins.out_enable_n = ($urandom_range(0, 3) == 0);
        last_addr_b = ins.addr_b;
        return ins;
    endfunction

    task automatic send_instr(input fbs_pkg::t_in_req ins);
        req_if.valid   <= 1'b1;
        req_if.payload <= ins;
        do @(posedge i_clk); while (!req_if.ready);
        predicted_rsp.push_back(predict_slice(ins));
        n_sent++;
    endtask

    task automatic idle_between();
        int n;
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
            n = $urandom_range(1, 9);
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue(input fbs_pkg::t_in_req ins);
        send_instr(ins);
        idle_between();
    endtask

    task automatic check_field(input string fname, input logic [3:0] exp,
                               input logic [3:0] got);
        if (exp !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        fbs_pkg::t_out_req exp;
        fbs_pkg::t_out_req got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (predicted_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                n_errors++;
            end else begin
                exp = predicted_rsp.pop_front();
                check_field("y_out",       exp.y_out,       got.y_out);
                check_field("y_driven",    exp.y_driven,    got.y_driven);
                check_field("carry_out",   exp.carry_out,   got.carry_out);
                check_field("propagate_n", exp.propagate_n, got.propagate_n);
                check_field("generate_n",  exp.generate_n,  got.generate_n);
                check_field("overflow",    exp.overflow,    got.overflow);
                check_field("f_zero",      exp.f_zero,      got.f_zero);
                check_field("f_sign",      exp.f_sign,      got.f_sign);
                check_field("ram0_out",    exp.ram0_out,    got.ram0_out);
                check_field("ram3_out",    exp.ram3_out,    got.ram3_out);
                check_field("q0_out",      exp.q0_out,      got.q0_out);
                check_field("q3_out",      exp.q3_out,      got.q3_out);
                n_checked++;
            end
        end
    end

    // result side back-pressure
    initial begin : rsp_throttle
        int hold;
        int stall_pct;
        int cyc;
        rsp_if.ready = 1'b0;
        hold      = 0;
        stall_pct = 0;
        cyc       = 0;
        forever begin
            @(posedge i_clk);
            if (cyc % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            cyc++;
            if (quiet) begin
                hold = 0;
                rsp_if.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                hold = $urandom_range(1, 9) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_reset_state();
        issue(build_instr(fbs_pkg::SRC_AQ, fbs_pkg::OP_ADD, fbs_pkg::DST_NOP,
                          4'hF, 4'h0, 4'h0, 1'b0));
        issue(build_instr(fbs_pkg::SRC_ZB, fbs_pkg::OP_OR, fbs_pkg::DST_NOP,
                          4'h0, 4'h7, 4'h0, 1'b0));
    endtask

    task automatic test_operations();
        fbs_pkg::t_in_req ins;
        issue(build_instr(fbs_pkg::SRC_DZ, fbs_pkg::OP_OR, fbs_pkg::DST_RAMF,
                          4'h0, 4'h1, 4'hF, 1'b0));
        issue(build_instr(fbs_pkg::SRC_DZ, fbs_pkg::OP_ADD, fbs_pkg::DST_RAMF,
                          4'h0, 4'h2, 4'h8, 1'b0));
        issue(build_instr(fbs_pkg::SRC_DZ, fbs_pkg::OP_ADD, fbs_pkg::DST_QREG,
                          4'h0, 4'h0, 4'h4, 1'b1));
        // every operation, each paired with a different operand source
        for (int k = 0; k < 8; k++) begin
            ins = build_instr(k[2:0], k[2:0], fbs_pkg::DST_NOP, 4'h1, 4'h2,
                              4'hA ^ k[3:0], k[0]);
            ins.out_enable_n = (k == 3);
            issue(ins);
        end
        // F + 8 + carry: carry out set, no overflow
        issue(build_instr(fbs_pkg::SRC_AB, fbs_pkg::OP_ADD, fbs_pkg::DST_NOP,
                          4'h1, 4'h2, 4'h0, 1'b1));
    endtask

    task automatic test_destinations();
        fbs_pkg::t_in_req ins;
        for (int k = 0; k < 8; k++) begin
            ins = build_instr(fbs_pkg::SRC_DA, fbs_pkg::OP_ADD, k[2:0], 4'h1, 4'h3,
                              4'h9, 1'b0);
            ins.ram0_in = k[0];
            ins.ram3_in = k[0];
            ins.q0_in   = ~k[0];
            ins.q3_in   = ~k[0];
            issue(ins);
        end
        // write then read the same entry back to back
        send_instr(build_instr(fbs_pkg::SRC_DZ, fbs_pkg::OP_EXOR, fbs_pkg::DST_RAMF,
                               4'h0, 4'h4, 4'h6, 1'b1));
        send_instr(build_instr(fbs_pkg::SRC_AB, fbs_pkg::OP_SUBS, fbs_pkg::DST_RAMU,
                               4'h4, 4'h4, 4'h0, 1'b1));
        idle_between();
    endtask

    task automatic test_random_programs(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 15;
                    default: src_idle_pct = 50;
                endcase
            end
            issue(random_instr());
        end
    endtask

    task automatic test_streaming(input int count);
        quiet = 1'b1;
        for (int i = 0; i < count; i++)
            send_instr(random_instr());
    endtask

    initial begin
        for (int i = 0; i < fbs_pkg::RF_DEPTH; i++)
            regfile_mirror[i] = '0;
        q_mirror       = '0;
        n_sent         = 0;
        n_checked      = 0;
        n_errors       = 0;
        src_idle_pct   = 20;
        quiet          = 1'b0;
        last_addr_b    = '0;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_operations();
        test_destinations();
        test_random_programs(1700);
        test_streaming(200);

        req_if.valid <= 1'b0;
        while (predicted_rsp.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (predicted_rsp.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, predicted_rsp.size());
            n_errors++;
        end
        $display("Ran %0d microinstructions, %0d results compared, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("Covered all sources, ALU functions, destinations and shifts under stalls");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
